// ===== rtl/htfd_pkg.sv =====
package htfd_pkg;

  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam int unsigned BUSY_BIT = 7;
  localparam logic [2:0] LAST_POS = 3'd6;
  localparam int unsigned RAW_W = 20;
  localparam int unsigned CNT_W = 32;
  localparam int unsigned HUM_W = 14;
  localparam int unsigned TEMP_W = 15;
  localparam logic [13:0] HUM_SCALE = 14'd10000;
  localparam logic [14:0] TEMP_SCALE = 15'd20000;
  localparam logic [14:0] TEMP_OFFSET = 15'd5000;
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_BUSY = 2'd1,
    ST_CRC  = 2'd2,
    ST_BUS  = 2'd3
  } status_t;

  typedef struct packed {
    status_t          status;
    logic [RAW_W-1:0] hraw;
    logic [RAW_W-1:0] traw;
  } event_t;

  typedef struct packed {
    logic   valid;
    event_t ev;
  } push_t;

  function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
  endfunction

endpackage

// ===== rtl/humidity_temp_frame_decoder_unit.sv =====
// Decodes a sensor measurement frame one byte per item; one item is taken every cycle
// unless the event queue is full (in_stall). The result for the item that completes a
// frame or reports a bus failure passes through the event queue, then the output register.
// The CRC step and constant multiplies are combinational: one item per cycle while not stalled.
// Synchronous active-low reset clears the byte position, the CRC to 0xFF, the queue
// and all statistics counters.
module humidity_temp_frame_decoder_unit #(
  parameter int unsigned QUEUE_DEPTH = htfd_pkg::QUEUE_DEPTH
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_action,
  input  logic [7:0]                         in_data_byte,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [1:0]                         out_status,
  output logic [htfd_pkg::HUM_W-1:0]         out_humidity_centi,
  output logic signed [htfd_pkg::TEMP_W-1:0] out_temp_centi,
  output logic [htfd_pkg::RAW_W-1:0]         out_humidity_raw,
  output logic [htfd_pkg::RAW_W-1:0]         out_temp_raw,
  output logic [htfd_pkg::CNT_W-1:0]         out_total_count,
  output logic [htfd_pkg::CNT_W-1:0]         out_success_count,
  output logic [htfd_pkg::CNT_W-1:0]         out_bus_error_count,
  output logic [htfd_pkg::CNT_W-1:0]         out_crc_error_count
);
  import htfd_pkg::*;

  push_t  push;
  event_t head;
  logic   q_full, q_nonempty, q_pop, accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  htfd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .action    (in_action),
    .data_byte (in_data_byte),
    .push      (push)
  );

  htfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (q_full),
    .nonempty (q_nonempty),
    .pop      (q_pop),
    .head     (head)
  );

  htfd_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .ev_valid            (q_nonempty),
    .ev                  (head),
    .ev_pop              (q_pop),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_humidity_centi  (out_humidity_centi),
    .out_temp_centi      (out_temp_centi),
    .out_humidity_raw    (out_humidity_raw),
    .out_temp_raw        (out_temp_raw),
    .out_total_count     (out_total_count),
    .out_success_count   (out_success_count),
    .out_bus_error_count (out_bus_error_count),
    .out_crc_error_count (out_crc_error_count)
  );

endmodule

// ===== rtl/htfd_front.sv =====
module htfd_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  logic               action,
  input  logic [7:0]         data_byte,
  output htfd_pkg::push_t    push
);
  import htfd_pkg::*;

  logic [2:0]       pos_r, pos_nxt;
  logic [7:0]       crc_r, crc_nxt;
  logic             busy_r, busy_nxt;
  logic [RAW_W-1:0] hacc_r, hacc_nxt;
  logic [RAW_W-1:0] tacc_r, tacc_nxt;
  logic [7:0]       crc_base;

  always_comb begin
    pos_nxt  = pos_r;
    crc_nxt  = crc_r;
    busy_nxt = busy_r;
    hacc_nxt = hacc_r;
    tacc_nxt = tacc_r;
    push     = '0;
    crc_base = (pos_r == 3'd0) ? CRC_INIT : crc_r;
    if (accept) begin
      if (action) begin
        pos_nxt          = 3'd0;
        crc_nxt          = CRC_INIT;
        push.valid       = 1'b1;
        push.ev.status   = ST_BUS;
      end else if (pos_r < LAST_POS) begin
        crc_nxt = crc_byte(crc_base, data_byte);
        pos_nxt = pos_r + 3'd1;
        case (pos_r)
          3'd0: busy_nxt = data_byte[BUSY_BIT];
          3'd1: hacc_nxt = {data_byte, 12'd0};
          3'd2: hacc_nxt = hacc_r | {8'd0, data_byte, 4'd0};
          3'd3: begin
            hacc_nxt = hacc_r | {16'd0, data_byte[7:4]};
            tacc_nxt = {data_byte[3:0], 16'd0};
          end
          3'd4: tacc_nxt = tacc_r | {4'd0, data_byte, 8'd0};
          default: tacc_nxt = tacc_r | {12'd0, data_byte};
        endcase
      end else begin
        pos_nxt        = 3'd0;
        crc_nxt        = CRC_INIT;
        push.valid     = 1'b1;
        push.ev.hraw   = hacc_r;
        push.ev.traw   = tacc_r;
        if (busy_r) begin
          push.ev.status = ST_BUSY;
        end else if (crc_r != data_byte) begin
          push.ev.status = ST_CRC;
        end else begin
          push.ev.status = ST_OK;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= 3'd0;
      crc_r  <= CRC_INIT;
      busy_r <= 1'b0;
      hacc_r <= '0;
      tacc_r <= '0;
    end else begin
      pos_r  <= pos_nxt;
      crc_r  <= crc_nxt;
      busy_r <= busy_nxt;
      hacc_r <= hacc_nxt;
      tacc_r <= tacc_nxt;
    end
  end

endmodule

// ===== rtl/htfd_queue.sv =====
module htfd_queue #(
  parameter int unsigned DEPTH = htfd_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  htfd_pkg::push_t  push,
  output logic             full,
  output logic             nonempty,
  input  logic             pop,
  output htfd_pkg::event_t head
);
  import htfd_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_QW = $clog2(DEPTH + 1);

  event_t            mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNT_QW-1:0] count_r;
  logic              do_push, do_pop;

  assign full     = (count_r == CNT_QW'(DEPTH));
  assign nonempty = (count_r != '0);
  assign head     = mem[rd_ptr_r];
  assign do_push  = push.valid && !full;
  assign do_pop   = pop && nonempty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push.ev;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/htfd_back.sv =====
module htfd_back (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   ev_valid,
  input  htfd_pkg::event_t                       ev,
  output logic                                   ev_pop,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [1:0]                             out_status,
  output logic [htfd_pkg::HUM_W-1:0]             out_humidity_centi,
  output logic signed [htfd_pkg::TEMP_W-1:0]     out_temp_centi,
  output logic [htfd_pkg::RAW_W-1:0]             out_humidity_raw,
  output logic [htfd_pkg::RAW_W-1:0]             out_temp_raw,
  output logic [htfd_pkg::CNT_W-1:0]             out_total_count,
  output logic [htfd_pkg::CNT_W-1:0]             out_success_count,
  output logic [htfd_pkg::CNT_W-1:0]             out_bus_error_count,
  output logic [htfd_pkg::CNT_W-1:0]             out_crc_error_count
);
  import htfd_pkg::*;

  localparam int unsigned HP_W = RAW_W + HUM_W;
  localparam int unsigned TP_W = RAW_W + TEMP_W;

  logic              valid_r;
  status_t           status_r;
  logic [HUM_W-1:0]  hum_r;
  logic [TEMP_W-1:0] temp_r;
  logic [RAW_W-1:0]  hraw_r, traw_r;
  logic [CNT_W-1:0]  total_r, succ_r, buserr_r, crcerr_r;
  logic [HP_W-1:0]   hum_prod;
  logic [TP_W-1:0]   temp_prod;
  logic              is_ok;

  assign ev_pop    = ev_valid && (!valid_r || !out_stall);
  assign hum_prod  = HP_W'(ev.hraw) * HP_W'(HUM_SCALE);
  assign temp_prod = TP_W'(ev.traw) * TP_W'(TEMP_SCALE);
  assign is_ok     = (ev.status == ST_OK);

  always_ff @(posedge clk) begin
    if (ev_pop) begin
      status_r <= ev.status;
      hraw_r   <= ev.hraw;
      traw_r   <= ev.traw;
      hum_r    <= is_ok ? hum_prod[HP_W-1:RAW_W] : '0;
      temp_r   <= is_ok ? temp_prod[TP_W-1:RAW_W] - TEMP_OFFSET : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= 1'b0;
      total_r  <= '0;
      succ_r   <= '0;
      buserr_r <= '0;
      crcerr_r <= '0;
    end else begin
      if (ev_pop) begin
        valid_r <= 1'b1;
        total_r <= sat_inc(total_r);
        case (ev.status)
          ST_OK:   succ_r   <= sat_inc(succ_r);
          ST_CRC:  crcerr_r <= sat_inc(crcerr_r);
          default: buserr_r <= sat_inc(buserr_r);
        endcase
      end else if (!out_stall) begin
        valid_r <= 1'b0;
      end
    end
  end

  assign out_valid           = valid_r;
  assign out_status          = status_r;
  assign out_humidity_centi  = hum_r;
  assign out_temp_centi      = temp_r;
  assign out_humidity_raw    = hraw_r;
  assign out_temp_raw        = traw_r;
  assign out_total_count     = total_r;
  assign out_success_count   = succ_r;
  assign out_bus_error_count = buserr_r;
  assign out_crc_error_count = crcerr_r;

endmodule

// ===== verif/humidity_temp_frame_decoder_unit_tb.sv =====
`timescale 1ns / 100ps

module humidity_temp_frame_decoder_unit_tb;
  import htfd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned ITEMS_PER_PHASE = 440;
  localparam int unsigned SETTLE_CYCLES = 8;

  typedef enum logic {
    ACT_BYTE     = 1'b0,
    ACT_BUS_FAIL = 1'b1
  } action_t;

  typedef struct {
    action_t    action;
    logic [7:0] data;
  } bus_item_t;

  typedef struct {
    status_t            status;
    logic [HUM_W-1:0]   hum_centi;
    logic [TEMP_W-1:0]  temp_centi;
    logic [RAW_W-1:0]   hum_raw;
    logic [RAW_W-1:0]   temp_raw;
    logic [CNT_W-1:0]   total;
    logic [CNT_W-1:0]   ok_frames;
    logic [CNT_W-1:0]   bus_fail_cnt;
    logic [CNT_W-1:0]   crc_fail_cnt;
  } frame_report_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_action = 1'b0;
  logic [7:0] in_data_byte = 8'h00;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_status;
  logic [HUM_W-1:0] out_humidity_centi;
  logic signed [TEMP_W-1:0] out_temp_centi;
  logic [RAW_W-1:0] out_humidity_raw;
  logic [RAW_W-1:0] out_temp_raw;
  logic [CNT_W-1:0] out_total_count;
  logic [CNT_W-1:0] out_success_count;
  logic [CNT_W-1:0] out_bus_error_count;
  logic [CNT_W-1:0] out_crc_error_count;

  bus_item_t pending_bytes[$];
  frame_report_t expected_reports[$];
  frame_report_t want;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned error_count = 0;
  int unsigned items_sent = 0;
  int unsigned reports_checked = 0;
  int unsigned status_seen[4] = '{0, 0, 0, 0};
  int unsigned cycle_count = 0;

  logic [2:0] frame_pos = 3'd0;
  logic [7:0] crc_acc = CRC_INIT;
  logic busy_flag = 1'b0;
  logic [RAW_W-1:0] hum_acc = '0;
  logic [RAW_W-1:0] temp_acc = '0;
  logic [CNT_W-1:0] cnt_total = '0;
  logic [CNT_W-1:0] cnt_ok = '0;
  logic [CNT_W-1:0] cnt_bus = '0;
  logic [CNT_W-1:0] cnt_crc = '0;

  humidity_temp_frame_decoder_unit uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_action(in_action),
    .in_data_byte(in_data_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_status(out_status),
    .out_humidity_centi(out_humidity_centi),
    .out_temp_centi(out_temp_centi),
    .out_humidity_raw(out_humidity_raw),
    .out_temp_raw(out_temp_raw),
    .out_total_count(out_total_count),
    .out_success_count(out_success_count),
    .out_bus_error_count(out_bus_error_count),
    .out_crc_error_count(out_crc_error_count)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] r;
    logic fb;
    r = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[7] ^ b[i];
      r = {r[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
    end
    return r;
  endfunction

  function automatic logic [CNT_W-1:0] bump_count(input logic [CNT_W-1:0] v);
    return (&v) ? v : v + 1;
  endfunction

  task automatic decode_byte(input action_t act, input logic [7:0] b);
    frame_report_t rep;
    logic [63:0] prod;
    rep.status = ST_BUS;
    rep.hum_centi = '0;
    rep.temp_centi = '0;
    rep.hum_raw = '0;
    rep.temp_raw = '0;
    if (act == ACT_BUS_FAIL) begin
      cnt_total = bump_count(cnt_total);
      cnt_bus = bump_count(cnt_bus);
      frame_pos = 3'd0;
      crc_acc = CRC_INIT;
    end else if (frame_pos < LAST_POS) begin
      crc_acc = crc8_next((frame_pos == 3'd0) ? CRC_INIT : crc_acc, b);
      case (frame_pos)
        3'd0: busy_flag = b[BUSY_BIT];
        3'd1: hum_acc = {b, 12'h000};
        3'd2: hum_acc[11:4] = b;
        3'd3: begin
          hum_acc[3:0] = b[7:4];
          temp_acc = {b[3:0], 16'h0000};
        end
        3'd4: temp_acc[15:8] = b;
        default: temp_acc[7:0] = b;
      endcase
      frame_pos = frame_pos + 3'd1;
      return;
    end else begin
      cnt_total = bump_count(cnt_total);
      rep.hum_raw = hum_acc;
      rep.temp_raw = temp_acc;
      if (busy_flag) begin
        cnt_bus = bump_count(cnt_bus);
        rep.status = ST_BUSY;
      end else if (crc_acc != b) begin
        cnt_crc = bump_count(cnt_crc);
        rep.status = ST_CRC;
      end else begin
        cnt_ok = bump_count(cnt_ok);
        rep.status = ST_OK;
        prod = 64'(hum_acc) * 64'd10000;
        rep.hum_centi = prod[20 +: HUM_W];
        prod = 64'(temp_acc) * 64'd20000;
        prod = (prod >> 20) - 64'd5000;
        rep.temp_centi = prod[TEMP_W-1:0];
      end
      frame_pos = 3'd0;
      crc_acc = CRC_INIT;
    end
    rep.total = cnt_total;
    rep.ok_frames = cnt_ok;
    rep.bus_fail_cnt = cnt_bus;
    rep.crc_fail_cnt = cnt_crc;
    expected_reports.push_back(rep);
  endtask

  task automatic check_field(input string what, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want_v, got_v);
      error_count++;
    end
  endtask

  task automatic queue_item(input action_t act, input logic [7:0] b);
    bus_item_t it;
    it.action = act;
    it.data = b;
    pending_bytes.push_back(it);
  endtask

  task automatic queue_frame(input logic [7:0] head, input logic [RAW_W-1:0] hraw,
                             input logic [RAW_W-1:0] traw, input logic [7:0] crc_flip);
    logic [7:0] bytes[7];
    logic [7:0] crc;
    bytes[0] = head;
    bytes[1] = hraw[19:12];
    bytes[2] = hraw[11:4];
    bytes[3] = {hraw[3:0], traw[19:16]};
    bytes[4] = traw[15:8];
    bytes[5] = traw[7:0];
    crc = CRC_INIT;
    for (int i = 0; i < 6; i++) begin
      crc = crc8_next(crc, bytes[i]);
    end
    bytes[6] = crc ^ crc_flip;
    for (int i = 0; i < 7; i++) begin
      queue_item(ACT_BYTE, bytes[i]);
    end
  endtask

  function automatic logic [RAW_W-1:0] pick_raw();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return RAW_W'($urandom);
    endcase
  endfunction

  task automatic wait_drained();
    while (pending_bytes.size() != 0 || expected_reports.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic fill_random_phase(input int unsigned count);
    int unsigned added;
    int unsigned kind;
    int unsigned n;
    logic [7:0] head;
    added = 0;
    while (added < count) begin
      kind = $urandom_range(0, 99);
      if (kind < 75) begin
        head = 8'($urandom);
        head[BUSY_BIT] = ($urandom_range(0, 99) < 15);
        queue_frame(head, pick_raw(), pick_raw(),
                    ($urandom_range(0, 99) < 15) ? 8'($urandom_range(1, 255)) : 8'h00);
        added += 7;
      end else if (kind < 85) begin
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) begin
          queue_item(ACT_BYTE, 8'($urandom));
        end
        queue_item(ACT_BUS_FAIL, 8'($urandom));
        added += n + 1;
      end else if (kind < 92) begin
        queue_item(ACT_BUS_FAIL, 8'($urandom));
        added += 1;
      end else begin
        n = $urandom_range(1, 10);
        for (int i = 0; i < n; i++) begin
          queue_item(($urandom_range(0, 7) == 0) ? ACT_BUS_FAIL : ACT_BYTE, 8'($urandom));
        end
        queue_item(ACT_BUS_FAIL, 8'($urandom));
        added += n + 1;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        decode_byte(action_t'(in_action), in_data_byte);
        void'(pending_bytes.pop_front());
        items_sent++;
      end
      if (!(in_valid && in_stall)) begin
        if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_action <= pending_bytes[0].action;
          in_data_byte <= pending_bytes[0].data;
        end else begin
          in_valid <= 1'b0;
          in_action <= 1'($urandom_range(0, 1));
          in_data_byte <= 8'($urandom);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_reports.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual status %0d", $time,
                   out_status);
          error_count++;
        end else begin
          want = expected_reports.pop_front();
          reports_checked++;
          status_seen[want.status]++;
          check_field("status", 32'(want.status), 32'(out_status));
          check_field("humidity_centi", 32'(want.hum_centi), 32'(out_humidity_centi));
          check_field("temp_centi", 32'(signed'(want.temp_centi)), 32'(out_temp_centi));
          check_field("humidity_raw", 32'(want.hum_raw), 32'(out_humidity_raw));
          check_field("temp_raw", 32'(want.temp_raw), 32'(out_temp_raw));
          check_field("total_count", want.total, out_total_count);
          check_field("success_count", want.ok_frames, out_success_count);
          check_field("bus_error_count", want.bus_fail_cnt, out_bus_error_count);
          check_field("crc_error_count", want.crc_fail_cnt, out_crc_error_count);
        end
      end
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int unsigned idle_plan[4][2];
    idle_plan = '{'{0, 0}, '{63, 0}, '{0, 63}, '{15, 15}};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed frames: full-scale raw fields, busy over a bad checksum, a bus
    // failure part way through a frame and one at the start, a checksum error.
    queue_frame(8'h00, '1, '1, 8'h00);
    queue_frame(8'h80, '0, '0, 8'h5A);
    queue_item(ACT_BYTE, 8'hFF);
    queue_item(ACT_BYTE, 8'h00);
    queue_item(ACT_BUS_FAIL, 8'hFF);
    queue_item(ACT_BUS_FAIL, 8'h00);
    queue_frame(8'h7F, 20'h80000, 20'h7FFFF, 8'h01);
    wait_drained();

    for (int p = 0; p < 4; p++) begin
      @(negedge clk);
      send_idle_pct = idle_plan[p][0];
      recv_stall_pct = idle_plan[p][1];
      fill_random_phase(ITEMS_PER_PHASE);
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d items and checked %0d results over four idling phases.",
             items_sent, reports_checked);
    $display("Results by status: ok %0d, busy %0d, crc %0d, bus %0d.",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
